/* src/status_led_pattern_controller_defines.svh */
// Assertion helpers shared by the RTL files.
`ifndef STATUS_LED_PATTERN_CONTROLLER_DEFINES_SVH
`define STATUS_LED_PATTERN_CONTROLLER_DEFINES_SVH

// Invariant checked on every clock edge outside reset.
`define SLPC_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent on this edge, consequent on the next one.
`define SLPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* src/slpc_pkg.sv */
`default_nettype none

package slpc_pkg;

  localparam int REG_W = 10;
  localparam int LVL_W = 7;

  typedef enum logic [2:0] {
    OP_TICK    = 3'd0,
    OP_PROFILE = 3'd1,
    OP_ACTIVE  = 3'd2,
    OP_USB     = 3'd3,
    OP_BATTERY = 3'd4
  } op_t;

  localparam logic [1:0] ACT_AWAKE = 2'd0;
  localparam logic [1:0] ACT_SLEEP = 2'd2;

  // highest profile number that blinks short
  localparam logic [2:0] SHORT_PROFILE_MAX = 3'd2;

  localparam logic [2:0] REG_SHORT_ON    = 3'd0;
  localparam logic [2:0] REG_SHORT_OFF   = 3'd1;
  localparam logic [2:0] REG_LONG_ON     = 3'd2;
  localparam logic [2:0] REG_LONG_OFF    = 3'd3;
  localparam logic [2:0] REG_PAIR_PERIOD = 3'd4;
  localparam logic [2:0] REG_BATT_PERIOD = 3'd5;
  localparam logic [2:0] REG_LOW_LIMIT   = 3'd6;

  localparam logic [REG_W-1:0] RST_SHORT_ON    = 10'd150;
  localparam logic [REG_W-1:0] RST_SHORT_OFF   = 10'd200;
  localparam logic [REG_W-1:0] RST_LONG_ON     = 10'd500;
  localparam logic [REG_W-1:0] RST_LONG_OFF    = 10'd200;
  localparam logic [REG_W-1:0] RST_PAIR_PERIOD = 10'd250;
  localparam logic [REG_W-1:0] RST_BATT_PERIOD = 10'd500;
  localparam logic [LVL_W-1:0] RST_LOW_LIMIT   = 7'd15;

  localparam int NUM_TMR = 3;

  typedef enum logic [1:0] {
    TMR_PROFILE = 2'd0,
    TMR_PAIRING = 2'd1,
    TMR_BATTERY = 2'd2
  } tmr_t;

  typedef struct packed {
    logic [2:0]       op;
    logic [2:0]       profile_index;
    logic             profile_is_open;
    logic [1:0]       activity_state;
    logic             usb_connected;
    logic [LVL_W-1:0] charge_level;
    logic             charger_active;
  } item_t;

  typedef struct packed {
    logic led_one;
    logic led_two;
  } result_t;

  typedef struct packed {
    logic [REG_W-1:0] short_on_ms;
    logic [REG_W-1:0] short_off_ms;
    logic [REG_W-1:0] long_on_ms;
    logic [REG_W-1:0] long_off_ms;
    logic [REG_W-1:0] pairing_period_ms;
    logic [REG_W-1:0] battery_period_ms;
    logic [LVL_W-1:0] low_level_limit;
  } cfg_regs_t;

endpackage

`default_nettype wire

/* src/slpc_cfg.sv */
`default_nettype none

module slpc_cfg (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     cfg_we,
  input  wire logic [2:0]               cfg_index,
  input  wire logic [slpc_pkg::REG_W-1:0] cfg_wdata,
  output slpc_pkg::cfg_regs_t           regs
);
  import slpc_pkg::*;

  cfg_regs_t regs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.short_on_ms       <= RST_SHORT_ON;
      regs_r.short_off_ms      <= RST_SHORT_OFF;
      regs_r.long_on_ms        <= RST_LONG_ON;
      regs_r.long_off_ms       <= RST_LONG_OFF;
      regs_r.pairing_period_ms <= RST_PAIR_PERIOD;
      regs_r.battery_period_ms <= RST_BATT_PERIOD;
      regs_r.low_level_limit   <= RST_LOW_LIMIT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SHORT_ON:    regs_r.short_on_ms       <= cfg_wdata;
        REG_SHORT_OFF:   regs_r.short_off_ms      <= cfg_wdata;
        REG_LONG_ON:     regs_r.long_on_ms        <= cfg_wdata;
        REG_LONG_OFF:    regs_r.long_off_ms       <= cfg_wdata;
        REG_PAIR_PERIOD: regs_r.pairing_period_ms <= cfg_wdata;
        REG_BATT_PERIOD: regs_r.battery_period_ms <= cfg_wdata;
        REG_LOW_LIMIT:   regs_r.low_level_limit   <= cfg_wdata[LVL_W-1:0];
        default: ;
      endcase
    end
  end

  assign regs = regs_r;

endmodule

`default_nettype wire

/* src/slpc_core.sv */
`default_nettype none

`include "status_led_pattern_controller_defines.svh"

module slpc_core #(
  parameter int TIMER_BITS = 10
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire slpc_pkg::cfg_regs_t cfg,
  input  wire logic                item_en,
  input  wire slpc_pkg::item_t     item,
  output slpc_pkg::result_t        leds
);
  import slpc_pkg::*;

  typedef logic [TIMER_BITS-1:0] tcnt_t;
  localparam tcnt_t TMAX = '1;

  function automatic tcnt_t sat_delay(input logic [REG_W-1:0] d);
    logic [31:0] d32;
    d32 = 32'(d);
    if (d32 > 32'(TMAX)) return TMAX;
    return d32[TIMER_BITS-1:0];
  endfunction

  // arming an armed timer keeps its count
  function automatic tcnt_t arm_cnt(input logic armed, input tcnt_t cnt,
                                    input logic [REG_W-1:0] d);
    return armed ? cnt : sat_delay(d);
  endfunction

  logic       led_one_r, led_one_nxt;
  logic       led_two_r, led_two_nxt;
  logic [2:0] profile_r, profile_nxt;
  logic       open_r, open_nxt;
  logic       usb_r, usb_nxt;
  logic       asleep_r, asleep_nxt;
  logic       low_r, low_nxt;
  logic [2:0] blinks_r, blinks_nxt;
  logic       long_r, long_nxt;
  logic       blink_lit_r, blink_lit_nxt;
  logic       sequence_running_r, sequence_running_nxt;
  logic       pair_first_r, pair_first_nxt;
  logic       pairing_running_r, pairing_running_nxt;
  logic       batt_lit_r, batt_lit_nxt;
  logic [NUM_TMR-1:0] armed_r, armed_nxt;
  tcnt_t      cnt_r [NUM_TMR];
  tcnt_t      cnt_nxt [NUM_TMR];
  logic [NUM_TMR-1:0] due;
  logic       batt_update;
  logic       pair_start;

  always_comb begin
    led_one_nxt          = led_one_r;
    led_two_nxt          = led_two_r;
    profile_nxt          = profile_r;
    open_nxt             = open_r;
    usb_nxt              = usb_r;
    asleep_nxt           = asleep_r;
    low_nxt              = low_r;
    blinks_nxt           = blinks_r;
    long_nxt             = long_r;
    blink_lit_nxt        = blink_lit_r;
    sequence_running_nxt = sequence_running_r;
    pair_first_nxt       = pair_first_r;
    pairing_running_nxt  = pairing_running_r;
    batt_lit_nxt         = batt_lit_r;
    armed_nxt            = armed_r;
    cnt_nxt              = cnt_r;
    due                  = '0;
    batt_update          = 1'b0;
    pair_start           = 1'b0;

    if (item_en) begin
      case (item.op)
        OP_TICK: begin
          for (int t = 0; t < NUM_TMR; t++) begin
            due[2'(t)] = armed_r[2'(t)] && (cnt_r[2'(t)] <= tcnt_t'(1));
            if (armed_r[2'(t)] && !due[2'(t)]) cnt_nxt[2'(t)] = cnt_r[2'(t)] - tcnt_t'(1);
          end

          if (due[TMR_PROFILE] && armed_nxt[TMR_PROFILE]) begin
            armed_nxt[TMR_PROFILE] = 1'b0;
            cnt_nxt[TMR_PROFILE]   = '0;
            if (asleep_nxt || !sequence_running_nxt || blink_lit_nxt) begin
              led_one_nxt = 1'b0;
              if (!asleep_nxt && sequence_running_nxt) begin
                blink_lit_nxt = 1'b0;
                blinks_nxt    = blinks_nxt - 3'd1;
              end
              if (asleep_nxt || !sequence_running_nxt || blinks_nxt == 3'd0) begin
                // sequence over: pick pairing back up if still wanted
                sequence_running_nxt = 1'b0;
                if (open_nxt && !asleep_nxt && !usb_nxt) begin
                  cnt_nxt[TMR_PAIRING] = arm_cnt(armed_nxt[TMR_PAIRING],
                      cnt_nxt[TMR_PAIRING], cfg.pairing_period_ms);
                  armed_nxt[TMR_PAIRING] = 1'b1;
                end
              end else begin
                cnt_nxt[TMR_PROFILE] = arm_cnt(armed_nxt[TMR_PROFILE], cnt_nxt[TMR_PROFILE],
                    long_nxt ? cfg.long_off_ms : cfg.short_off_ms);
                armed_nxt[TMR_PROFILE] = 1'b1;
              end
            end else begin
              blink_lit_nxt = 1'b1;
              led_one_nxt   = 1'b1;
              cnt_nxt[TMR_PROFILE] = arm_cnt(armed_nxt[TMR_PROFILE], cnt_nxt[TMR_PROFILE],
                  long_nxt ? cfg.long_on_ms : cfg.short_on_ms);
              armed_nxt[TMR_PROFILE] = 1'b1;
            end
          end

          if (due[TMR_PAIRING] && armed_nxt[TMR_PAIRING]) begin
            armed_nxt[TMR_PAIRING] = 1'b0;
            cnt_nxt[TMR_PAIRING]   = '0;
            if (asleep_nxt || !open_nxt || sequence_running_nxt || usb_nxt) begin
              led_one_nxt         = 1'b0;
              led_two_nxt         = 1'b0;
              pairing_running_nxt = 1'b0;
            end else begin
              pair_first_nxt = !pair_first_nxt;
              led_one_nxt    = pair_first_nxt;
              led_two_nxt    = !pair_first_nxt;
              cnt_nxt[TMR_PAIRING] = arm_cnt(armed_nxt[TMR_PAIRING], cnt_nxt[TMR_PAIRING],
                  cfg.pairing_period_ms);
              armed_nxt[TMR_PAIRING] = 1'b1;
            end
          end

          if (due[TMR_BATTERY] && armed_nxt[TMR_BATTERY]) begin
            armed_nxt[TMR_BATTERY] = 1'b0;
            cnt_nxt[TMR_BATTERY]   = '0;
            if (asleep_nxt || pairing_running_nxt) begin
              batt_lit_nxt = 1'b0;
            end else if (usb_nxt || low_nxt) begin
              if (usb_nxt) begin
                batt_lit_nxt = item.charger_active;
              end else begin
                batt_lit_nxt = !batt_lit_nxt;
              end
              led_two_nxt = batt_lit_nxt;
              cnt_nxt[TMR_BATTERY] = arm_cnt(armed_nxt[TMR_BATTERY], cnt_nxt[TMR_BATTERY],
                  cfg.battery_period_ms);
              armed_nxt[TMR_BATTERY] = 1'b1;
            end else begin
              led_two_nxt  = 1'b0;
              batt_lit_nxt = 1'b0;
            end
          end
        end

        OP_PROFILE: begin
          profile_nxt = item.profile_index;
          open_nxt    = item.profile_is_open;
          if (!asleep_r) begin
            armed_nxt[TMR_PAIRING] = 1'b0;
            cnt_nxt[TMR_PAIRING]   = '0;
            pairing_running_nxt    = 1'b0;
            led_two_nxt            = 1'b0;
            if (item.profile_index <= SHORT_PROFILE_MAX) begin
              blinks_nxt = item.profile_index + 3'd1;
              long_nxt   = 1'b0;
            end else begin
              blinks_nxt = item.profile_index - SHORT_PROFILE_MAX;
              long_nxt   = 1'b1;
            end
            blink_lit_nxt        = 1'b1;
            sequence_running_nxt = 1'b1;
            led_one_nxt          = 1'b1;
            // loaded without arm_cnt, so this always loads, even over an armed count
            cnt_nxt[TMR_PROFILE]   = sat_delay(long_nxt ? cfg.long_on_ms : cfg.short_on_ms);
            armed_nxt[TMR_PROFILE] = 1'b1;
          end
          if (!item.profile_is_open) begin
            armed_nxt[TMR_PAIRING] = 1'b0;
            cnt_nxt[TMR_PAIRING]   = '0;
            pairing_running_nxt    = 1'b0;
            led_one_nxt            = 1'b0;
            led_two_nxt            = 1'b0;
            batt_update            = 1'b1;
          end
        end

        OP_ACTIVE: begin
          if (item.activity_state == ACT_SLEEP) begin
            asleep_nxt           = 1'b1;
            armed_nxt            = '0;
            for (int t = 0; t < NUM_TMR; t++) cnt_nxt[2'(t)] = '0;
            led_one_nxt          = 1'b0;
            led_two_nxt          = 1'b0;
            sequence_running_nxt = 1'b0;
            pairing_running_nxt  = 1'b0;
          end else if (item.activity_state == ACT_AWAKE) begin
            asleep_nxt = 1'b0;
            if (open_r && !usb_r) pair_start = 1'b1;
            else batt_update = 1'b1;
          end
        end

        OP_USB: begin
          usb_nxt = item.usb_connected;
          if (!asleep_r) begin
            if (item.usb_connected && !usb_r) begin
              armed_nxt[TMR_PAIRING] = 1'b0;
              cnt_nxt[TMR_PAIRING]   = '0;
              pairing_running_nxt    = 1'b0;
              led_one_nxt            = 1'b0;
              led_two_nxt            = 1'b0;
              batt_update            = 1'b1;
            end else if (!item.usb_connected && usb_r) begin
              if (open_r) pair_start = 1'b1;
              else batt_update = 1'b1;
            end
          end
        end

        OP_BATTERY: begin
          low_nxt = item.charge_level <= cfg.low_level_limit;
          if (low_nxt != low_r) batt_update = 1'b1;
        end

        default: ;
      endcase
    end

    // both of these are always the last action of the request
    if (pair_start && !asleep_nxt && open_nxt && !sequence_running_nxt && !usb_nxt) begin
      pairing_running_nxt = 1'b1;
      pair_first_nxt      = 1'b1;
      led_one_nxt         = 1'b1;
      led_two_nxt         = 1'b0;
      cnt_nxt[TMR_PAIRING] = arm_cnt(armed_nxt[TMR_PAIRING], cnt_nxt[TMR_PAIRING],
          cfg.pairing_period_ms);
      armed_nxt[TMR_PAIRING] = 1'b1;
    end

    if (batt_update && !asleep_nxt && !pairing_running_nxt) begin
      if (usb_nxt || low_nxt) begin
        // refresh on the next tick, unless the battery timer is already armed
        cnt_nxt[TMR_BATTERY] = arm_cnt(armed_nxt[TMR_BATTERY], cnt_nxt[TMR_BATTERY], '0);
        armed_nxt[TMR_BATTERY] = 1'b1;
      end else begin
        armed_nxt[TMR_BATTERY] = 1'b0;
        cnt_nxt[TMR_BATTERY]   = '0;
        led_two_nxt            = 1'b0;
        batt_lit_nxt           = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      led_one_r          <= 1'b0;
      led_two_r          <= 1'b0;
      profile_r          <= '0;
      open_r             <= 1'b0;
      usb_r              <= 1'b0;
      asleep_r           <= 1'b0;
      low_r              <= 1'b0;
      blinks_r           <= '0;
      long_r             <= 1'b0;
      blink_lit_r        <= 1'b0;
      sequence_running_r <= 1'b0;
      pair_first_r       <= 1'b0;
      pairing_running_r  <= 1'b0;
      batt_lit_r         <= 1'b0;
      armed_r            <= '0;
      for (int t = 0; t < NUM_TMR; t++) cnt_r[2'(t)] <= '0;
    end else begin
      led_one_r          <= led_one_nxt;
      led_two_r          <= led_two_nxt;
      profile_r          <= profile_nxt;
      open_r             <= open_nxt;
      usb_r              <= usb_nxt;
      asleep_r           <= asleep_nxt;
      low_r              <= low_nxt;
      blinks_r           <= blinks_nxt;
      long_r             <= long_nxt;
      blink_lit_r        <= blink_lit_nxt;
      sequence_running_r <= sequence_running_nxt;
      pair_first_r       <= pair_first_nxt;
      pairing_running_r  <= pairing_running_nxt;
      batt_lit_r         <= batt_lit_nxt;
      armed_r            <= armed_nxt;
      cnt_r              <= cnt_nxt;
    end
  end

  assign leds.led_one = led_one_r;
  assign leds.led_two = led_two_r;

  // nothing can arm a timer or light an LED while asleep
  `SLPC_ASSERT(a_sleep_dark, clk, rst_n, !asleep_r || (!led_one_r && !led_two_r && armed_r == '0), "LED or timer active while asleep")
  `SLPC_ASSERT(a_pair_seq_excl, clk, rst_n, !(pairing_running_r && sequence_running_r), "pairing and profile blink both running")
  `SLPC_ASSERT(a_disarmed_zero, clk, rst_n, (armed_r[TMR_PROFILE] || cnt_r[TMR_PROFILE] == '0) && (armed_r[TMR_PAIRING] || cnt_r[TMR_PAIRING] == '0) && (armed_r[TMR_BATTERY] || cnt_r[TMR_BATTERY] == '0), "disarmed timer holds a count")

endmodule

`default_nettype wire

/* src/status_led_pattern_controller.sv */
// Two-LED status indicator. Every request on in_ (a 1 ms tick or an event:
// profile change, activity change, USB change, battery level) yields exactly
// one result on out_ carrying both LED levels after that request. A request
// is registered on acceptance and applied to the state from that register,
// where the result register loads; out_stall on a held result delays this.
// One request per cycle is sustained while out_ is not stalled; the state update
// loop sets that rate. Registers on cfg_ may be written only while no request is
// in flight. After reset both LEDs are off, all timers disarmed, block awake.
`default_nettype none

`include "status_led_pattern_controller_defines.svh"

module status_led_pattern_controller #(
  parameter int TIMER_BITS = 10
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_we,
  input  wire logic [2:0]                 cfg_index,
  input  wire logic [slpc_pkg::REG_W-1:0] cfg_wdata,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire slpc_pkg::item_t            in_data,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output slpc_pkg::result_t               out_data
);
  import slpc_pkg::*;

  cfg_regs_t regs;
  logic      in_valid_r, in_valid_nxt;
  item_t     in_data_r;
  logic      out_valid_r, out_valid_nxt;
  logic      advance;
  logic      in_take;

  slpc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .regs      (regs)
  );

  // LED state registers double as the result register
  slpc_core #(
    .TIMER_BITS (TIMER_BITS)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (regs),
    .item_en (advance),
    .item    (in_data_r),
    .leds    (out_data)
  );

  assign advance  = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    in_valid_nxt  = in_take || (in_valid_r && !advance);
    out_valid_nxt = advance || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) in_data_r <= in_data;
  end

  assign out_valid = out_valid_r;

  `SLPC_ASSERT_NEXT(a_adv_out, clk, rst_n, advance, out_valid_r, "applied request produced no result")
  `SLPC_ASSERT_NEXT(a_hold_in, clk, rst_n, in_valid_r && !advance, in_valid_r && $stable(in_data_r), "pending request lost")

endmodule

`default_nettype wire
